@@ src/orb_pkg.sv @@
// Shared types and constants for the overwrite ring buffer.
`timescale 1ns / 1ps
`default_nettype none

package orb_pkg;

  localparam int unsigned DefDepth = 1024;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CapW     = 11;
  localparam int unsigned OpW      = 2;

  localparam logic [DataW-1:0] EmptyWord = 32'hABCDEF01;

  typedef enum logic [OpW-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef struct packed {
    logic take;
  } cmd_t;

endpackage

`default_nettype wire

@@ src/orb_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module orb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ src/orb_ctrl.sv @@
// Handshake controller: tracks whether a result is held at the output.
`timescale 1ns / 1ps
`default_nettype none

module orb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output orb_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HOLD = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign out_valid_o = (state_q == ST_HOLD);
  assign in_ready_o  = (state_q == ST_IDLE) || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign cmd_o.take  = take;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_ready_i && !in_valid_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ src/orb_datapath.sv @@
// Pointers, overwrite counter, capacity register and word store.
`timescale 1ns / 1ps
`default_nettype none

module orb_datapath #(
  parameter int unsigned DEPTH = orb_pkg::DefDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire orb_pkg::cmd_t               cmd_i,
  input  wire logic [orb_pkg::OpW-1:0]     opcode_i,
  input  wire logic [orb_pkg::DataW-1:0]   push_data_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [orb_pkg::CapW-1:0]    cfg_wdata_i,
  output logic      [orb_pkg::DataW-1:0]   pop_data_o,
  output logic                             pop_ok_o,
  output logic                             overwrote_o,
  output logic      [orb_pkg::CapW-1:0]    fill_count_o,
  output logic      [orb_pkg::DataW-1:0]   overwrite_total_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = (CW > orb_pkg::CapW) ? CW : orb_pkg::CapW;

  logic [IW-1:0]             wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d;
  logic                      lap_q, lap_d;
  logic [orb_pkg::DataW-1:0] cnt_q, cnt_d;
  logic [CW-1:0]             cap_q, cap_d;
  logic                      pop_ok_q, pop_ok_d, ovw_q, ovw_d;

  logic [CW-1:0]             wr_ext, rd_ext, wr_inc, rd_inc, fill_now;
  logic [EW-1:0]             cfg_ext, fill_ext;
  logic                      full;
  logic                      ram_we, ram_re;
  logic [orb_pkg::DataW-1:0] ram_rdata;

  assign wr_ext   = CW'(wr_idx_q);
  assign rd_ext   = CW'(rd_idx_q);
  assign wr_inc   = wr_ext + CW'(1);
  assign rd_inc   = rd_ext + CW'(1);
  assign full     = lap_q && (wr_idx_q == rd_idx_q);
  assign fill_now = lap_q ? (cap_q - rd_ext + wr_ext) : (wr_ext - rd_ext);
  assign cfg_ext  = EW'(cfg_wdata_i);
  assign fill_ext = EW'(fill_now);

  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    lap_d    = lap_q;
    cnt_d    = cnt_q;
    cap_d    = cap_q;
    pop_ok_d = pop_ok_q;
    ovw_d    = ovw_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    if (cfg_we_i) begin
      if (cfg_ext == '0) begin
        cap_d = CW'(1);
      end else if (cfg_ext > EW'(DEPTH)) begin
        cap_d = CW'(DEPTH);
      end else begin
        cap_d = cfg_ext[CW-1:0];
      end
      wr_idx_d = '0;
      rd_idx_d = '0;
      lap_d    = 1'b0;
      cnt_d    = '0;
    end else if (cmd_i.take) begin
      pop_ok_d = 1'b0;
      ovw_d    = 1'b0;
      unique case (orb_pkg::op_e'(opcode_i))
        orb_pkg::OP_PUSH: begin
          ram_we = 1'b1;
          if (full) begin
            // drop the oldest word
            rd_idx_d = (rd_inc >= cap_q) ? '0 : rd_inc[IW-1:0];
            cnt_d    = cnt_q + orb_pkg::DataW'(1);
            ovw_d    = 1'b1;
          end
          if (wr_inc >= cap_q) begin
            wr_idx_d = '0;
            lap_d    = 1'b1;
          end else begin
            wr_idx_d = wr_inc[IW-1:0];
          end
        end
        orb_pkg::OP_POP: begin
          if (fill_now != '0) begin
            ram_re   = 1'b1;
            pop_ok_d = 1'b1;
            if (rd_inc >= cap_q) begin
              rd_idx_d = '0;
              lap_d    = 1'b0;
            end else begin
              rd_idx_d = rd_inc[IW-1:0];
            end
          end
        end
        orb_pkg::OP_CLEAR: begin
          wr_idx_d = '0;
          rd_idx_d = '0;
          lap_d    = 1'b0;
        end
        orb_pkg::OP_NOP: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      lap_q    <= 1'b0;
      cnt_q    <= '0;
      cap_q    <= CW'(DEPTH);
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      lap_q    <= lap_d;
      cnt_q    <= cnt_d;
      cap_q    <= cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pop_ok_q <= pop_ok_d;
    ovw_q    <= ovw_d;
  end

  orb_ram #(
    .WIDTH (orb_pkg::DataW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (push_data_i),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign pop_data_o        = pop_ok_q ? ram_rdata : orb_pkg::EmptyWord;
  assign pop_ok_o          = pop_ok_q;
  assign overwrote_o       = ovw_q;
  assign fill_count_o      = fill_ext[orb_pkg::CapW-1:0];
  assign overwrite_total_o = cnt_q;

  a_cap_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q != '0) && (cap_q <= CW'(DEPTH)))
    else $error("capacity out of range");

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ext < cap_q) && (rd_ext < cap_q))
    else $error("pointer beyond capacity");

  a_fill_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_now <= cap_q)
    else $error("fill count above capacity");

  a_empty_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take && !cfg_we_i && (opcode_i == orb_pkg::OP_POP) && (fill_now == '0))
      |=> !pop_ok_q)
    else $error("pop from empty buffer returned data");

  a_ovw_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take && !cfg_we_i && (opcode_i == orb_pkg::OP_PUSH) && full)
      |=> (ovw_q && (cnt_q == $past(cnt_q) + orb_pkg::DataW'(1))))
    else $error("overwrite not counted");

endmodule

`default_nettype wire

@@ src/overwrite_ring_buffer.sv @@
// Top level of the overwrite ring buffer: controller plus datapath.
//
//   channel  direction  signals
//   in       request    in_valid_i / in_ready_o, opcode_i, push_data_i
//   out      result     out_valid_o / out_ready_i, pop_data_o, pop_ok_o,
//                       overwrote_o, fill_count_o, overwrite_total_o
//   cfg      write      cfg_we_i, cfg_wdata_i (capacity)
//
// One request per cycle while out_ready_i is high; its result is valid the cycle after acceptance.
// The next request is accepted in the same cycle the held result is taken.
// Pop data comes from the word store's registered read port in the cycle after the pop is accepted.
// Reset empties the buffer, zeroes the counter and sets capacity to DEPTH.
// A stalled result holds; new requests wait until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module overwrite_ring_buffer #(
  parameter int unsigned DEPTH = orb_pkg::DefDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [orb_pkg::OpW-1:0]     opcode_i,
  input  wire logic [orb_pkg::DataW-1:0]   push_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [orb_pkg::DataW-1:0]   pop_data_o,
  output logic                             pop_ok_o,
  output logic                             overwrote_o,
  output logic      [orb_pkg::CapW-1:0]    fill_count_o,
  output logic      [orb_pkg::DataW-1:0]   overwrite_total_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [orb_pkg::CapW-1:0]    cfg_wdata_i
);

  orb_pkg::cmd_t cmd;

  orb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  orb_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .opcode_i          (opcode_i),
    .push_data_i       (push_data_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .pop_data_o        (pop_data_o),
    .pop_ok_o          (pop_ok_o),
    .overwrote_o       (overwrote_o),
    .fill_count_o      (fill_count_o),
    .overwrite_total_o (overwrite_total_o)
  );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for overwrite_ring_buffer: directed table, random phases, predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned PtrW       = $clog2(orb_pkg::DefDepth);
  localparam int          RandItems  = 830;
  localparam int          HoldAt     = 200;
  localparam int          HoldCycles = 80;
  localparam int          IdleLimit  = 2000;

  typedef struct packed {
    logic [orb_pkg::DataW-1:0] pop_data;
    logic                      pop_ok;
    logic                      overwrote;
    logic [orb_pkg::CapW-1:0]  fill_count;
    logic [orb_pkg::DataW-1:0] overwrite_total;
  } ring_res_t;

  typedef enum {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                 kind;
    orb_pkg::op_e              op;
    logic [orb_pkg::DataW-1:0] word;
    bit                        typed;
    ring_res_t                 res;
  } row_t;

  typedef enum {STALL_NONE, STALL_HALF, STALL_QUARTER, STALL_TOGGLE} stall_e;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic [orb_pkg::OpW-1:0]   opcode    = '0;
  logic [orb_pkg::DataW-1:0] push_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [orb_pkg::DataW-1:0] pop_data;
  logic                      pop_ok;
  logic                      overwrote;
  logic [orb_pkg::CapW-1:0]  fill_count;
  logic [orb_pkg::DataW-1:0] overwrite_total;
  logic                      cfg_we    = 1'b0;
  logic [orb_pkg::CapW-1:0]  cfg_wdata = '0;

  bit               req_typed = 1'b0;
  ring_res_t        req_res   = '0;

  ring_res_t        pending_res[$];
  row_t             dir_rows[$];

  logic [orb_pkg::DataW-1:0] word_mem [orb_pkg::DefDepth];
  logic [PtrW-1:0]           wr_ptr;
  logic [PtrW-1:0]           rd_ptr;
  logic                      lap;
  logic [orb_pkg::CapW-1:0]  cap_words;
  logic [orb_pkg::DataW-1:0] ovw_count;

  int errors          = 0;
  int reqs_taken      = 0;
  int results_checked = 0;
  int cfg_writes      = 0;
  int ovw_seen        = 0;
  int pops_ok         = 0;
  int idle_cycles     = 0;
  int burst_left      = 0;
  bit hold_done       = 1'b0;

  overwrite_ring_buffer i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .opcode_i         (opcode),
    .push_data_i      (push_data),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .pop_data_o       (pop_data),
    .pop_ok_o         (pop_ok),
    .overwrote_o      (overwrote),
    .fill_count_o     (fill_count),
    .overwrite_total_o(overwrite_total),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [orb_pkg::CapW-1:0] ring_fill();
    if (lap) begin
      return cap_words - orb_pkg::CapW'(rd_ptr) + orb_pkg::CapW'(wr_ptr);
    end
    return orb_pkg::CapW'(wr_ptr) - orb_pkg::CapW'(rd_ptr);
  endfunction

  function automatic void ring_config(input logic [orb_pkg::CapW-1:0] v);
    if (v == 0) begin
      cap_words = orb_pkg::CapW'(1);
    end else if (v > orb_pkg::DefDepth) begin
      cap_words = orb_pkg::CapW'(orb_pkg::DefDepth);
    end else begin
      cap_words = v;
    end
    wr_ptr    = '0;
    rd_ptr    = '0;
    lap       = 1'b0;
    ovw_count = '0;
  endfunction

  function automatic ring_res_t ring_step(input orb_pkg::op_e op,
                                         input logic [orb_pkg::DataW-1:0] word);
    ring_res_t r;
    r          = '0;
    r.pop_data = orb_pkg::EmptyWord;
    case (op)
      orb_pkg::OP_PUSH: begin
        if (lap && wr_ptr == rd_ptr) begin
          rd_ptr      = (orb_pkg::CapW'(rd_ptr) + 1 >= cap_words) ? '0 : rd_ptr + 1'b1;
          ovw_count   = ovw_count + 1'b1;
          r.overwrote = 1'b1;
        end
        word_mem[wr_ptr] = word;
        if (orb_pkg::CapW'(wr_ptr) + 1 >= cap_words) begin
          wr_ptr = '0;
          lap    = 1'b1;
        end else begin
          wr_ptr = wr_ptr + 1'b1;
        end
      end
      orb_pkg::OP_POP: begin
        if (ring_fill() != 0) begin
          r.pop_data = word_mem[rd_ptr];
          r.pop_ok   = 1'b1;
          if (orb_pkg::CapW'(rd_ptr) + 1 >= cap_words) begin
            rd_ptr = '0;
            lap    = 1'b0;
          end else begin
            rd_ptr = rd_ptr + 1'b1;
          end
        end
      end
      orb_pkg::OP_CLEAR: begin
        wr_ptr = '0;
        rd_ptr = '0;
        lap    = 1'b0;
      end
      default: begin
      end
    endcase
    r.fill_count      = ring_fill();
    r.overwrite_total = ovw_count;
    return r;
  endfunction

  function automatic void row_req(input orb_pkg::op_e op,
                                  input logic [orb_pkg::DataW-1:0] word);
    row_t row;
    row.kind  = ROW_REQ;
    row.op    = op;
    row.word  = word;
    row.typed = 1'b0;
    row.res   = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void row_chk(input orb_pkg::op_e op,
                                  input logic [orb_pkg::DataW-1:0] word,
                                  input logic [orb_pkg::DataW-1:0] pdata, input logic ok,
                                  input logic ovw, input int fill, input int total);
    row_t row;
    row.kind                = ROW_REQ;
    row.op                  = op;
    row.word                = word;
    row.typed               = 1'b1;
    row.res.pop_data        = pdata;
    row.res.pop_ok          = ok;
    row.res.overwrote       = ovw;
    row.res.fill_count      = orb_pkg::CapW'(fill);
    row.res.overwrite_total = orb_pkg::DataW'(total);
    dir_rows.push_back(row);
  endfunction

  function automatic void row_cfg(input int v);
    row_t row;
    row.kind  = ROW_CFG;
    row.op    = orb_pkg::OP_NOP;
    row.word  = orb_pkg::DataW'(v);
    row.typed = 1'b0;
    row.res   = '0;
    dir_rows.push_back(row);
  endfunction

  task automatic cmp_field(input string name, input logic [orb_pkg::DataW-1:0] want,
                           input logic [orb_pkg::DataW-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic offer_req(input orb_pkg::op_e op, input logic [orb_pkg::DataW-1:0] word,
                           input bit typed, input ring_res_t res);
    @(negedge clk);
    in_valid  <= 1'b1;
    opcode    <= op;
    push_data <= word;
    req_typed <= typed;
    req_res   <= res;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
  endtask

  task automatic write_capacity(input logic [orb_pkg::CapW-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    ring_config(v);
    cfg_writes++;
  endtask

  always @(posedge clk) begin
    ring_res_t want;
    ring_res_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.pop_data        = pop_data;
        got.pop_ok          = pop_ok;
        got.overwrote       = overwrote;
        got.fill_count      = fill_count;
        got.overwrite_total = overwrite_total;
        if (pending_res.size() == 0) begin
          $display("%0t ns: result with no request outstanding, got %0h", $time, got);
          errors++;
        end else begin
          want = pending_res.pop_front();
          cmp_field("pop_data", want.pop_data, got.pop_data);
          cmp_field("pop_ok", orb_pkg::DataW'(want.pop_ok), orb_pkg::DataW'(got.pop_ok));
          cmp_field("overwrote", orb_pkg::DataW'(want.overwrote),
                    orb_pkg::DataW'(got.overwrote));
          cmp_field("fill_count", orb_pkg::DataW'(want.fill_count),
                    orb_pkg::DataW'(got.fill_count));
          cmp_field("overwrite_total", want.overwrite_total, got.overwrite_total);
          results_checked++;
        end
      end
      if (in_valid && in_ready) begin
        want = ring_step(orb_pkg::op_e'(opcode), push_data);
        if (req_typed) begin
          want = req_res;
        end
        pending_res.push_back(want);
        reqs_taken++;
        if (want.overwrote) ovw_seen++;
        if (want.pop_ok) pops_ok++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t ns: no handshake for %0d cycles", $time, IdleLimit);
        $display("overwrite_ring_buffer verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Hold off once long enough for the block to fill and stall its input.
  initial begin
    stall_e mode;
    int     left;
    mode = STALL_NONE;
    left = 0;
    forever begin
      @(negedge clk);
      if (!hold_done && reqs_taken >= HoldAt) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        if (left == 0) begin
          mode = stall_e'($urandom_range(0, 3));
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          STALL_NONE:    out_ready <= 1'b1;
          STALL_HALF:    out_ready <= 1'($urandom_range(0, 1));
          STALL_QUARTER: out_ready <= ($urandom_range(0, 3) == 0);
          default:       out_ready <= ~out_ready;
        endcase
      end
    end
  end

  initial begin
    int                        rand_done;
    int                        phase_items;
    int                        push_w;
    int                        r;
    orb_pkg::op_e              op;
    logic [orb_pkg::DataW-1:0] word;
    logic [orb_pkg::CapW-1:0]  cap;

    ring_config(orb_pkg::CapW'(orb_pkg::DefDepth));
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    row_chk(orb_pkg::OP_POP,   32'h0,        orb_pkg::EmptyWord, 1'b0, 1'b0, 0, 0);
    row_chk(orb_pkg::OP_NOP,   32'hFFFFFFFF, orb_pkg::EmptyWord, 1'b0, 1'b0, 0, 0);
    row_chk(orb_pkg::OP_PUSH,  32'hFFFFFFFF, orb_pkg::EmptyWord, 1'b0, 1'b0, 1, 0);
    row_chk(orb_pkg::OP_PUSH,  32'h00000000, orb_pkg::EmptyWord, 1'b0, 1'b0, 2, 0);
    row_chk(orb_pkg::OP_POP,   32'h0,        32'hFFFFFFFF,       1'b1, 1'b0, 1, 0);
    row_chk(orb_pkg::OP_CLEAR, 32'h55555555, orb_pkg::EmptyWord, 1'b0, 1'b0, 0, 0);
    row_chk(orb_pkg::OP_POP,   32'h0,        orb_pkg::EmptyWord, 1'b0, 1'b0, 0, 0);
    row_cfg(0);
    row_chk(orb_pkg::OP_PUSH,  32'hA5A5A5A5, orb_pkg::EmptyWord, 1'b0, 1'b0, 1, 0);
    row_chk(orb_pkg::OP_PUSH,  32'h5A5A5A5A, orb_pkg::EmptyWord, 1'b0, 1'b1, 1, 1);
    row_chk(orb_pkg::OP_PUSH,  32'h12345678, orb_pkg::EmptyWord, 1'b0, 1'b1, 1, 2);
    row_chk(orb_pkg::OP_POP,   32'h0,        32'h12345678,       1'b1, 1'b0, 0, 2);
    row_chk(orb_pkg::OP_POP,   32'h0,        orb_pkg::EmptyWord, 1'b0, 1'b0, 0, 2);
    row_chk(orb_pkg::OP_CLEAR, 32'h0,        orb_pkg::EmptyWord, 1'b0, 1'b0, 0, 2);
    row_chk(orb_pkg::OP_NOP,   32'h0,        orb_pkg::EmptyWord, 1'b0, 1'b0, 0, 2);
    row_cfg(2047);
    row_chk(orb_pkg::OP_PUSH,  32'h80000001, orb_pkg::EmptyWord, 1'b0, 1'b0, 1, 0);
    row_cfg(2);
    row_chk(orb_pkg::OP_PUSH,  32'h11111111, orb_pkg::EmptyWord, 1'b0, 1'b0, 1, 0);
    row_chk(orb_pkg::OP_PUSH,  32'h22222222, orb_pkg::EmptyWord, 1'b0, 1'b0, 2, 0);
    row_chk(orb_pkg::OP_PUSH,  32'h33333333, orb_pkg::EmptyWord, 1'b0, 1'b1, 2, 1);
    row_chk(orb_pkg::OP_POP,   32'h0,        32'h22222222,       1'b1, 1'b0, 1, 1);
    row_req(orb_pkg::OP_PUSH,  32'h44444444);
    row_req(orb_pkg::OP_POP,   32'h0);
    row_req(orb_pkg::OP_POP,   32'h0);
    row_req(orb_pkg::OP_POP,   32'h0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_capacity(dir_rows[i].word[orb_pkg::CapW-1:0]);
      end else begin
        offer_req(dir_rows[i].op, dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res);
        pace();
      end
    end

    rand_done = 0;
    while (rand_done < RandItems) begin
      r = $urandom_range(0, 15);
      if (r == 0) begin
        cap = '0;
      end else if (r == 1) begin
        cap = '1;
      end else if (r == 2) begin
        cap = orb_pkg::CapW'(orb_pkg::DefDepth);
      end else if (r <= 9) begin
        cap = orb_pkg::CapW'($urandom_range(1, 8));
      end else if (r <= 13) begin
        cap = orb_pkg::CapW'($urandom_range(9, 64));
      end else if (r == 14) begin
        cap = orb_pkg::CapW'($urandom_range(65, 2047));
      end else begin
        cap = orb_pkg::CapW'(1);
      end
      write_capacity(cap);
      phase_items = $urandom_range(20, 70);
      push_w      = $urandom_range(30, 75);
      repeat (phase_items) begin
        r = $urandom_range(0, 99);
        if (r < push_w) begin
          op = orb_pkg::OP_PUSH;
        end else if (r >= 97) begin
          op = orb_pkg::OP_NOP;
        end else if (r >= 93) begin
          op = orb_pkg::OP_CLEAR;
        end else begin
          op = orb_pkg::OP_POP;
        end
        r = $urandom_range(0, 19);
        word = (r == 0) ? '0 : (r == 1) ? '1 : orb_pkg::DataW'($urandom);
        offer_req(op, word, 1'b0, '0);
        pace();
        rand_done++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Ran %0d requests (%0d from the table) over %0d capacity settings, %0d results checked.",
             reqs_taken, dir_rows.size() - 3, cfg_writes, results_checked);
    $display("Saw %0d overwrites and %0d good pops; output held off once for %0d cycles.",
             ovw_seen, pops_ok, HoldCycles);
    if (errors == 0) begin
      $display("overwrite_ring_buffer verification clean");
    end else begin
      $display("overwrite_ring_buffer verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/orb_pkg.sv
src/orb_ram.sv
src/orb_ctrl.sv
src/orb_datapath.sv
src/overwrite_ring_buffer.sv
tb/tb_top.sv
